// ===== rtl/life_grid_generation_engine_assert.svh =====
// assertion macros for the life grid engine
// used by the top level only, no other dependencies
`ifndef LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LGGE_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lgge assertion failed");

// next-cycle implication, checked out of reset
`define LGGE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lgge assertion failed");

`endif

// ===== rtl/lgge_pkg.sv =====
// shared types and constants for the life grid engine
// no dependencies
package lgge_pkg;

  localparam int unsigned GRID_ROWS_DEF = 64;
  localparam int unsigned GRID_COLS_DEF = 64;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_TOGGLE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       cell_value;
  } life_in_t;

  typedef struct packed {
    logic        cell_state;
    logic [31:0] generation_count;
  } life_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_CLEAR,
    ST_STEP
  } state_t;

endpackage

// ===== rtl/life_grid_generation_engine.sv =====
// life grid engine: write, toggle, read, clear, and B3/S23 generation step
// uses lgge_pkg and life_grid_generation_engine_assert.svh
// write, toggle, read: result strobe on return to idle, next word accepted then.
// clear: one memory row zeroed per cycle; result on the cycle after the last row.
// step: one row read and one new row written per cycle through a three-row
// window over the single row memory; result on the cycle after.
// reset: busy stays high through a clearing pass; counter resets to zero.
// results are strobed for one cycle on out_valid and cannot be held off.
`include "life_grid_generation_engine_assert.svh"

module life_grid_generation_engine #(
  parameter int unsigned GRID_ROWS = lgge_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = lgge_pkg::GRID_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lgge_pkg::life_in_t in_data,
  output logic               out_valid,
  output lgge_pkg::life_out_t out_data
);

  localparam int unsigned RW   = $clog2(GRID_ROWS);
  localparam int unsigned CNTW = $clog2(GRID_ROWS + 2);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data_r;

  lgge_pkg::state_t    state_r, state_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  lgge_pkg::life_in_t  cmd_r, cmd_nxt;
  logic [31:0]         gen_r, gen_nxt;
  logic [GRID_COLS-1:0] up_r, up_nxt, mid_r, mid_nxt;
  logic                cell_r, cell_nxt;
  logic                report_r, report_nxt;
  logic                out_valid_r, out_valid_nxt;
  lgge_pkg::life_out_t out_data_r, out_data_nxt;

  logic                 mem_we;
  logic [RW-1:0]        mem_waddr, mem_raddr;
  logic [GRID_COLS-1:0] mem_wdata;

  logic                 accept;
  logic                 on_grid;
  logic [GRID_COLS-1:0] col_mask;
  logic [GRID_COLS-1:0] rmw_word;
  logic [GRID_COLS-1:0] rmw_shift;
  logic [GRID_COLS-1:0] dn_row;
  logic [GRID_COLS-1:0] life_row;
  logic [GRID_COLS-1:0] life_shift;
  logic [GRID_COLS+1:0] pad_up, pad_mid, pad_dn;
  logic [3:0]           nbr [GRID_COLS];
  logic [CNTW-1:0]      cnt_m2;
  logic                 clear_last, step_last, row_hit;

  assign accept   = start && (state_r == lgge_pkg::ST_IDLE);
  assign busy     = (state_r != lgge_pkg::ST_IDLE);
  assign on_grid  = (32'(cmd_r.row_index) < GRID_ROWS) && (32'(cmd_r.col_index) < GRID_COLS);
  assign col_mask = GRID_COLS'(1) << cmd_r.col_index;
  assign cnt_m2   = cnt_r - CNTW'(2);
  assign clear_last = (cnt_r == CNTW'(GRID_ROWS - 1));
  assign step_last  = (cnt_r == CNTW'(GRID_ROWS + 1));
  assign row_hit    = on_grid && (32'(cmd_r.row_index) + 32'd2 == 32'(cnt_r));

  // read-modify-write of the addressed row
  always_comb begin
    unique case (cmd_r.opcode)
      lgge_pkg::OP_WRITE:  rmw_word = cmd_r.cell_value ? (rd_data_r | col_mask)
                                                       : (rd_data_r & ~col_mask);
      lgge_pkg::OP_TOGGLE: rmw_word = rd_data_r ^ col_mask;
      default:             rmw_word = rd_data_r;
    endcase
  end
  assign rmw_shift = rmw_word >> cmd_r.col_index;

  // three-row window rule, rows and columns beyond the edge are dead
  assign dn_row  = (32'(cnt_r) <= GRID_ROWS) ? rd_data_r : '0;
  assign pad_up  = {1'b0, up_r, 1'b0};
  assign pad_mid = {1'b0, mid_r, 1'b0};
  assign pad_dn  = {1'b0, dn_row, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      nbr[c] = {3'b000, pad_up[c]} + {3'b000, pad_up[c+1]} + {3'b000, pad_up[c+2]}
             + {3'b000, pad_mid[c]} + {3'b000, pad_mid[c+2]}
             + {3'b000, pad_dn[c]} + {3'b000, pad_dn[c+1]} + {3'b000, pad_dn[c+2]};
      life_row[c] = (nbr[c] == 4'd3) || ((nbr[c] == 4'd2) && mid_r[c]);
    end
  end
  assign life_shift = life_row >> cmd_r.col_index;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lgge_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_data.opcode)
            lgge_pkg::OP_CLEAR: state_nxt = lgge_pkg::ST_CLEAR;
            lgge_pkg::OP_STEP:  state_nxt = lgge_pkg::ST_STEP;
            default:            state_nxt = lgge_pkg::ST_RMW;
          endcase
        end
      end
      lgge_pkg::ST_RMW:   state_nxt = lgge_pkg::ST_IDLE;
      lgge_pkg::ST_CLEAR: if (clear_last) state_nxt = lgge_pkg::ST_IDLE;
      lgge_pkg::ST_STEP:  if (step_last) state_nxt = lgge_pkg::ST_IDLE;
      default:            state_nxt = lgge_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    gen_nxt       = gen_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    cell_nxt      = cell_r;
    report_nxt    = report_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[RW-1:0];
    mem_wdata     = '0;
    mem_raddr     = RW'(in_data.row_index);
    unique case (state_r)
      lgge_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_data;
          cnt_nxt    = '0;
          up_nxt     = '0;
          mid_nxt    = '0;
          cell_nxt   = 1'b0;
          report_nxt = 1'b1;
        end
      end
      lgge_pkg::ST_RMW: begin
        mem_we    = on_grid && ((cmd_r.opcode == lgge_pkg::OP_WRITE) ||
                                (cmd_r.opcode == lgge_pkg::OP_TOGGLE));
        mem_waddr = RW'(cmd_r.row_index);
        mem_wdata = rmw_word;
        out_valid_nxt = 1'b1;
        out_data_nxt.cell_state       = on_grid ? rmw_shift[0] : 1'b0;
        out_data_nxt.generation_count = gen_r;
      end
      lgge_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[RW-1:0];
        cnt_nxt   = cnt_r + CNTW'(1);
        gen_nxt   = '0;
        if (clear_last) begin
          out_valid_nxt = report_r;
          out_data_nxt.cell_state       = 1'b0;
          out_data_nxt.generation_count = '0;
        end
      end
      lgge_pkg::ST_STEP: begin
        mem_raddr = cnt_r[RW-1:0];
        mem_we    = (cnt_r >= CNTW'(2));
        mem_waddr = cnt_m2[RW-1:0];
        mem_wdata = life_row;
        cnt_nxt   = cnt_r + CNTW'(1);
        if (cnt_r != '0) begin
          up_nxt  = mid_r;
          mid_nxt = dn_row;
        end
        if (mem_we && row_hit) cell_nxt = life_shift[0];
        if (step_last) begin
          gen_nxt = gen_r + 32'd1;
          out_valid_nxt = 1'b1;
          out_data_nxt.cell_state       = (mem_we && row_hit) ? life_shift[0] : cell_r;
          out_data_nxt.generation_count = gen_r + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgge_pkg::ST_CLEAR;
      cnt_r       <= '0;
      gen_r       <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LGGE_ASSERT_NOW(a_result_when_idle, clk, rst_n, out_valid_r, state_r == lgge_pkg::ST_IDLE)
  `LGGE_ASSERT_NOW(a_no_write_idle, clk, rst_n, state_r == lgge_pkg::ST_IDLE, !mem_we)
  `LGGE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `LGGE_ASSERT_NEXT(a_gen_held_idle, clk, rst_n, state_r == lgge_pkg::ST_IDLE, $stable(gen_r))

endmodule

// ===== sim/life_grid_generation_engine_tb.sv =====
// self-checking testbench for the life grid engine: a directed command table, then
// random episodes of patterns and generation steps, every result word checked
// depends on lgge_pkg and rtl/life_grid_generation_engine.sv
module life_grid_generation_engine_tb;

  localparam int unsigned NR = lgge_pkg::GRID_ROWS_DEF;
  localparam int unsigned NC = lgge_pkg::GRID_COLS_DEF;
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int RANDOM_CMDS = 1600;
  localparam int TAIL_CMDS = 150;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    lgge_pkg::life_in_t  cmd;
    bit                  typed;
    lgge_pkg::life_out_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  lgge_pkg::life_in_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  lgge_pkg::life_out_t out_data;

  logic [NC-1:0]       grid_model [NR];
  logic [31:0]         gen_model;
  lgge_pkg::life_out_t pending_results [$];
  lgge_pkg::life_out_t want;
  dir_row_t            dir_tab [$];

  int cmds_sent = 0;
  int cmd_target = 0;
  int steps_sent = 0;
  int clears_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  life_grid_generation_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  function automatic lgge_pkg::life_in_t mk_cmd(logic [2:0] op, int r, int c, int v);
    lgge_pkg::life_in_t w;
    w.opcode     = op;
    w.row_index  = r[5:0];
    w.col_index  = c[5:0];
    w.cell_value = v[0];
    return w;
  endfunction

  function automatic lgge_pkg::life_out_t mk_res(int cs, int gen);
    lgge_pkg::life_out_t w;
    w.cell_state       = cs[0];
    w.generation_count = 32'(gen);
    return w;
  endfunction

  function automatic logic cell_model(int r, int c);
    if (r < 0 || r >= NR || c < 0 || c >= NC) return 1'b0;
    return grid_model[r][c];
  endfunction

  function automatic void advance_model();
    logic [NC-1:0] nxt [NR];
    int n;
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NC; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += int'(cell_model(r + dr, c + dc));
          end
        end
        nxt[r][c] = (n == 3) || (n == 2 && grid_model[r][c]);
      end
    end
    grid_model = nxt;
    gen_model = gen_model + 32'd1;
  endfunction

  function automatic lgge_pkg::life_out_t apply_command(lgge_pkg::life_in_t cmd);
    int r;
    int c;
    bit on;
    r = int'(cmd.row_index);
    c = int'(cmd.col_index);
    on = (r < NR) && (c < NC);
    case (cmd.opcode)
      lgge_pkg::OP_WRITE: begin
        if (on) grid_model[r][c] = cmd.cell_value;
      end
      lgge_pkg::OP_TOGGLE: begin
        if (on) grid_model[r][c] = ~grid_model[r][c];
      end
      lgge_pkg::OP_CLEAR: begin
        for (int i = 0; i < NR; i++) grid_model[i] = '0;
        gen_model = '0;
      end
      lgge_pkg::OP_STEP: begin
        advance_model();
      end
      default: begin
      end
    endcase
    return mk_res(int'(cell_model(r, c)), int'(gen_model));
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic issue(input lgge_pkg::life_in_t cmd, input bit typed,
                       input lgge_pkg::life_out_t typed_res);
    lgge_pkg::life_out_t predicted;
    int gap;
    if (cmds_sent < cmd_target - TAIL_CMDS && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_data = cmd;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_command(cmd);
    pending_results.push_back(typed ? typed_res : predicted);
    cmds_sent++;
    if (cmd.opcode == lgge_pkg::OP_STEP) steps_sent++;
    if (cmd.opcode == lgge_pkg::OP_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: cell_state %0b generation_count %0d",
               out_data.cell_state, out_data.generation_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.cell_state !== want.cell_state) begin
          $error("cell_state expected %0b actual %0b", want.cell_state, out_data.cell_state);
          mismatches++;
        end
        if (out_data.generation_count !== want.generation_count) begin
          $error("generation_count expected %0d actual %0d",
                 want.generation_count, out_data.generation_count);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int w;
    int r0;
    int c0;
    int seeds;
    int reads;
    logic [2:0] op;

    // reset state, extremes, toggles and spare opcodes, then a step and a clear
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_READ, 0, 0, 0), 1'b1, mk_res(0, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_READ, 63, 63, 1), 1'b1, mk_res(0, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 0, 0, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 63, 63, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 63, 63, 0), 1'b1, mk_res(0, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 0, 63, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_TOGGLE, 63, 0, 0), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_TOGGLE, 63, 0, 1), 1'b1, mk_res(0, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_TOGGLE, 63, 63, 0), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(OP_SPARE_A, 0, 0, 0), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(OP_SPARE_B, 0, 63, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(OP_SPARE_C, 1, 1, 1), 1'b1, mk_res(0, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_STEP, 0, 0, 1), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_CLEAR, 0, 63, 1), 1'b1, mk_res(0, 0)});
    // blinker in the middle, corner pattern that grows into a block
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 31, 30, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 31, 31, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 31, 32, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 62, 63, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 63, 62, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_WRITE, 63, 63, 1), 1'b1, mk_res(1, 0)});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_STEP, 30, 31, 0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_READ, 62, 62, 0), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_STEP, 31, 30, 1), 1'b0, '0});
    dir_tab.push_back('{mk_cmd(lgge_pkg::OP_READ, 32, 31, 0), 1'b0, '0});

    cmd_target = dir_tab.size() + RANDOM_CMDS;
    for (int i = 0; i < NR; i++) grid_model[i] = '0;
    gen_model = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) issue(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);

    // episodes: sometimes clear, seed a small window, step it a few times, probe it, plus some noise
    while (cmds_sent < cmd_target) begin
      w = $urandom_range(3, 6);
      case ($urandom_range(0, 3))
        0: r0 = 0;
        1: r0 = NR - w;
        default: r0 = $urandom_range(0, NR - w);
      endcase
      case ($urandom_range(0, 3))
        0: c0 = 0;
        1: c0 = NC - w;
        default: c0 = $urandom_range(0, NC - w);
      endcase
      if ($urandom_range(0, 11) == 0) begin
        issue(mk_cmd(lgge_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1)), 1'b0, '0);
      end
      seeds = $urandom_range(3, 12);
      repeat (seeds) begin
        op = ($urandom_range(0, 4) == 0) ? lgge_pkg::OP_TOGGLE : lgge_pkg::OP_WRITE;
        issue(mk_cmd(op, r0 + $urandom_range(0, w - 1), c0 + $urandom_range(0, w - 1),
                     int'($urandom_range(0, 4) != 0)), 1'b0, '0);
      end
      repeat ($urandom_range(1, 4)) begin
        issue(mk_cmd(lgge_pkg::OP_STEP, r0 + $urandom_range(0, w - 1),
                     c0 + $urandom_range(0, w - 1), $urandom_range(0, 1)), 1'b0, '0);
        reads = $urandom_range(0, 2);
        repeat (reads) begin
          issue(mk_cmd(lgge_pkg::OP_READ, r0 + $urandom_range(0, w - 1),
                       c0 + $urandom_range(0, w - 1), $urandom_range(0, 1)), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        issue(mk_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1)), 1'b0, '0);
      end
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NR + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      mismatches++;
    end

    $display("sent %0d commands (%0d generation steps, %0d clears), checked %0d results",
             cmds_sent, steps_sent, clears_sent, results_checked);
    $display("mismatches: %0d, cycles: %0d", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
